@@ sv/mlq_pkg.sv @@
// Shared types, codes and helpers for the multilevel queue scheduler.
// Used by the job cell chain and the scheduler top level; no dependencies.
package mlq_pkg;

    // One job as held by a cell of the chain
    typedef struct packed {
        logic        valid;
        logic [15:0] number;
        logic [1:0]  level;
        logic [7:0]  wait_cnt;
    } entry_t;

    // One buffered enqueue or remove command
    typedef struct packed {
        logic        is_remove;
        logic [15:0] target;
        logic [1:0]  prio;
    } cmd_t;

    // Cell operations
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_AGE   = 2'd1;
    localparam logic [1:0] CELL_SORT  = 2'd2;
    localparam logic [1:0] CELL_SHIFT = 2'd3;

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0] op;
        logic       parity;
        logic       load;
        logic [7:0] elapsed;
        logic [7:0] threshold;
    } cell_ctl_t;

    // Input modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_ENQUEUE = 2'd1;
    localparam logic [1:0] MODE_REMOVE  = 2'd2;
    localparam logic [1:0] MODE_FINISH  = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_CMD_FULL   = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND  = 2'd3;

    // Queue levels
    localparam logic [1:0] LEVEL_NONE  = 2'd0;
    localparam logic [1:0] LEVEL_ONE   = 2'd1;
    localparam logic [1:0] LEVEL_TWO   = 2'd2;
    localparam logic [1:0] LEVEL_THREE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SLICE_ONE   = 2'd0;
    localparam logic [1:0] REG_SLICE_TWO   = 2'd1;
    localparam logic [1:0] REG_SLICE_THREE = 2'd2;
    localparam logic [1:0] REG_THRESHOLD   = 2'd3;

    // One result item
    typedef struct packed {
        logic [15:0] assigned_job;
        logic [1:0]  running_level;
        logic [15:0] running_job;
        logic        running_valid;
        logic        pass_done;
        logic [1:0]  status;
    } result_t;

    // Sort key: levels in order, empty cells last
    function automatic logic [2:0] sort_key(entry_t e);
        return e.valid ? {1'b0, e.level} : 3'd4;
    endfunction

    // Slice length of a level, a zero register acting as one tick
    function automatic logic [7:0] slice_pick(logic [1:0] level, logic [7:0] s1,
                                              logic [7:0] s2, logic [7:0] s3);
        logic [7:0] v;
        case (level)
            LEVEL_THREE: v = s3;
            LEVEL_TWO:   v = s2;
            default:     v = s1;
        endcase
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ sv/mlq_ram.sv @@
// Generic single write port RAM with one registered read port.
// No dependencies; holds the command buffer of the scheduler.
module mlq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mlq_cell.sv @@
// One cell of the job chain: holds a waiting job and ages, sorts or shifts it.
// Depends on mlq_pkg for the entry and control types.
module mlq_cell #(
    parameter int unsigned IDX  = 0,
    parameter bit          LAST = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mlq_pkg::cell_ctl_t ctl,
    input  mlq_pkg::entry_t    left,
    input  mlq_pkg::entry_t    right,
    input  mlq_pkg::entry_t    tail,
    output mlq_pkg::entry_t    ent
);
    import mlq_pkg::*;

    localparam bit ODD   = (IDX % 2) == 1;
    localparam bit FIRST = (IDX == 0);

    logic        valid_reg, valid_next;
    entry_t      data_reg, data_next;
    entry_t      cur;
    logic [8:0]  sum;
    logic [7:0]  sat;

    always_comb
    begin
        cur       = data_reg;
        cur.valid = valid_reg;
    end

    // Select the next content of this cell
    always_comb
    begin
        data_next = cur;
        sum       = {1'b0, cur.wait_cnt} + {1'b0, ctl.elapsed};
        sat       = sum[8] ? 8'hFF : sum[7:0];
        case (ctl.op)
            CELL_AGE:
            begin
                if (LAST && ctl.load)
                begin
                    data_next = tail;
                end
                else if (cur.valid)
                begin
                    data_next.wait_cnt = sat;
                    if ((cur.level == LEVEL_TWO || cur.level == LEVEL_THREE)
                        && sat >= ctl.threshold)
                    begin
                        data_next.level    = cur.level - 2'd1;
                        data_next.wait_cnt = 8'd0;
                    end
                end
            end
            CELL_SORT:
            begin
                if (ODD == ctl.parity)
                begin
                    if (!LAST && sort_key(cur) > sort_key(right))
                    begin
                        data_next = right;
                    end
                end
                else
                begin
                    if (!FIRST && sort_key(left) > sort_key(cur))
                    begin
                        data_next = left;
                    end
                end
            end
            CELL_SHIFT:
            begin
                data_next = LAST ? tail : right;
            end
            default:
            begin
                data_next = cur;
            end
        endcase
        valid_next = data_next.valid;
    end

    // Hold the valid flag; reset clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ent = cur;

endmodule

@@ sv/multilevel_queue_job_scheduler.sv @@
// Multilevel queue job scheduler with aging, built on a chain of job cells.
// Depends on mlq_pkg, mlq_ram (command buffer) and mlq_cell (job chain).
// An item that runs no pass has its result registered in the cycle after transfer.
// A pass runs the states AGE, SORT_A, PICK, SORT_C and DONE, with ROT and SORT_B before PICK
// for a remove command that misses the running job; each SORT state is an odd-even sweep.
// One item at a time; results wait in a two-entry output queue.
// Reset (rst_n, async low) empties the chain, the levels, the command buffer.
module multilevel_queue_job_scheduler #(
    parameter int unsigned JOB_SLOTS     = 16,
    parameter int unsigned COMMAND_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // target_job[15:0], priority_req[17:16], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], pass_done[2], running_valid[3],
                                   // running_job[19:4], running_level[21:20],
                                   // assigned_job[37:22], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mlq_pkg::*;

    localparam int unsigned RND_W = $clog2(JOB_SLOTS);
    localparam int unsigned CNT_W = $clog2(JOB_SLOTS + 1);
    localparam int unsigned PTR_W = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
    localparam int unsigned CCW   = $clog2(COMMAND_DEPTH + 1);
    localparam int unsigned CMD_W = $bits(cmd_t);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AGE    = 3'd1;
    localparam logic [2:0] ST_SORT_A = 3'd2;
    localparam logic [2:0] ST_ROT    = 3'd3;
    localparam logic [2:0] ST_SORT_B = 3'd4;
    localparam logic [2:0] ST_PICK   = 3'd5;
    localparam logic [2:0] ST_SORT_C = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic [7:0]       countdown_reg, countdown_next;
    logic [15:0]      number_reg, number_next;
    logic [CNT_W-1:0] job_count_reg, job_count_next;
    logic             run_valid_reg, run_valid_next;
    logic             run_finished_reg, run_finished_next;
    logic [15:0]      run_number_reg, run_number_next;
    logic [1:0]       run_level_reg, run_level_next;
    logic             need_rot_reg, need_rot_next;
    logic             found_reg, found_next;
    logic [1:0]       pass_status_reg, pass_status_next;
    logic [15:0]      assigned_reg, assigned_next;
    logic [15:0]      target_reg, target_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CCW-1:0]   cmd_cnt_reg, cmd_cnt_next;
    logic [7:0]       slice_one_reg, slice_two_reg, slice_three_reg, threshold_reg;
    result_t          q_reg [2];
    result_t          q_next [2];
    logic [1:0]       q_cnt_reg, q_cnt_next;

    logic             s_fire, pop, push;
    result_t          push_data;
    logic [1:0]       mode;
    cmd_t             in_cmd, head_cmd;
    logic [CMD_W-1:0] ram_rdata;
    logic             ram_we;
    logic [15:0]      new_number;
    logic [1:0]       enq_level;
    logic             load;
    logic             match;
    logic             round_last;
    logic             run_keep;
    cell_ctl_t        ctl;
    entry_t           tail;
    entry_t           cell_q  [JOB_SLOTS];
    entry_t           left_in [JOB_SLOTS];
    entry_t           right_in[JOB_SLOTS];

    assign mode      = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE) && (q_cnt_reg != 2'd2);
    assign s_fire    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    assign in_cmd.is_remove = (mode == MODE_REMOVE);
    assign in_cmd.target    = s_tdata[15:0];
    assign in_cmd.prio      = s_tdata[17:16];
    assign head_cmd         = cmd_t'(ram_rdata);

    assign new_number = (number_reg == 16'hFFFF) ? 16'd1 : number_reg + 16'd1;
    assign enq_level  = (head_cmd.prio == LEVEL_NONE) ? LEVEL_ONE : head_cmd.prio;
    assign round_last = (round_reg == RND_W'(JOB_SLOTS - 1));
    assign match      = cell_q[0].valid && (cell_q[0].number == target_reg) && !found_reg;
    assign run_keep   = run_valid_reg && !run_finished_reg;
    assign load       = (state_reg == ST_AGE) && (cmd_cnt_reg != '0) && !head_cmd.is_remove
                        && (job_count_reg != CNT_W'(JOB_SLOTS));

    // Command buffer storage
    mlq_ram #(
        .WIDTH (CMD_W),
        .DEPTH (COMMAND_DEPTH),
        .AW    (PTR_W)
    ) u_cmd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (in_cmd),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Drive the cell chain control
    always_comb
    begin
        ctl.op        = CELL_HOLD;
        ctl.parity    = round_reg[0];
        ctl.load      = load;
        ctl.elapsed   = run_valid_reg ? slice_pick(run_level_reg, slice_one_reg,
                                                   slice_two_reg, slice_three_reg) : 8'd1;
        ctl.threshold = threshold_reg;
        tail          = cell_q[0];
        case (state_reg)
            ST_AGE:
            begin
                ctl.op        = CELL_AGE;
                tail.valid    = 1'b1;
                tail.number   = new_number;
                tail.level    = enq_level;
                tail.wait_cnt = 8'd0;
            end
            ST_SORT_A, ST_SORT_B, ST_SORT_C:
            begin
                ctl.op = CELL_SORT;
            end
            ST_ROT:
            begin
                ctl.op     = CELL_SHIFT;
                tail.valid = cell_q[0].valid && !match;
            end
            ST_PICK:
            begin
                ctl.op        = cell_q[0].valid ? CELL_SHIFT : CELL_HOLD;
                tail.valid    = run_keep;
                tail.number   = run_number_reg;
                tail.level    = run_level_reg;
                tail.wait_cnt = 8'd0;
            end
            default:
            begin
                ctl.op = CELL_HOLD;
            end
        endcase
    end

    // Job cell chain
    for (genvar i = 0; i < JOB_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = cell_q[i];
        end
        else
        begin : g_mid
            assign left_in[i] = cell_q[i-1];
        end
        if (i == JOB_SLOTS - 1)
        begin : g_last
            assign right_in[i] = tail;
        end
        else
        begin : g_inner
            assign right_in[i] = cell_q[i+1];
        end
        mlq_cell #(
            .IDX  (i),
            .LAST (i == JOB_SLOTS - 1)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .left  (left_in[i]),
            .right (right_in[i]),
            .tail  (tail),
            .ent   (cell_q[i])
        );
    end

    // Sequence items and scheduling passes
    always_comb
    begin
        state_next        = state_reg;
        round_next        = round_reg;
        countdown_next    = countdown_reg;
        number_next       = number_reg;
        job_count_next    = job_count_reg;
        run_valid_next    = run_valid_reg;
        run_finished_next = run_finished_reg;
        run_number_next   = run_number_reg;
        run_level_next    = run_level_reg;
        need_rot_next     = need_rot_reg;
        found_next        = found_reg;
        pass_status_next  = pass_status_reg;
        assigned_next     = assigned_reg;
        target_next       = target_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        cmd_cnt_next      = cmd_cnt_reg;
        ram_we            = 1'b0;
        push              = 1'b0;
        push_data.status        = STATUS_OK;
        push_data.pass_done     = 1'b0;
        push_data.running_valid = run_valid_reg;
        push_data.running_job   = run_valid_reg ? run_number_reg : 16'd0;
        push_data.running_level = run_valid_reg ? run_level_reg : LEVEL_NONE;
        push_data.assigned_job  = 16'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (mode)
                        MODE_TICK:
                        begin
                            if (countdown_reg > 8'd1)
                            begin
                                countdown_next = countdown_reg - 8'd1;
                                push           = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_AGE;
                            end
                        end
                        MODE_ENQUEUE, MODE_REMOVE:
                        begin
                            push = 1'b1;
                            if (cmd_cnt_reg == CCW'(COMMAND_DEPTH))
                            begin
                                push_data.status = STATUS_CMD_FULL;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                cmd_cnt_next = cmd_cnt_reg + CCW'(1);
                                wr_ptr_next  = (wr_ptr_reg == PTR_W'(COMMAND_DEPTH - 1))
                                               ? '0 : wr_ptr_reg + PTR_W'(1);
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                            if (run_valid_reg)
                            begin
                                run_finished_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_AGE:
            begin
                pass_status_next = STATUS_OK;
                assigned_next    = 16'd0;
                need_rot_next    = 1'b0;
                found_next       = 1'b0;
                target_next      = head_cmd.target;
                round_next       = '0;
                state_next       = ST_SORT_A;
                if (cmd_cnt_reg != '0)
                begin
                    cmd_cnt_next = cmd_cnt_reg - CCW'(1);
                    rd_ptr_next  = (rd_ptr_reg == PTR_W'(COMMAND_DEPTH - 1))
                                   ? '0 : rd_ptr_reg + PTR_W'(1);
                    if (head_cmd.is_remove)
                    begin
                        if (run_valid_reg && run_number_reg == head_cmd.target)
                        begin
                            run_valid_next    = 1'b0;
                            run_finished_next = 1'b0;
                            job_count_next    = job_count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            need_rot_next = 1'b1;
                        end
                    end
                    else if (load)
                    begin
                        number_next    = new_number;
                        assigned_next  = new_number;
                        job_count_next = job_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pass_status_next = STATUS_TABLE_FULL;
                    end
                end
            end
            ST_SORT_A:
            begin
                round_next = round_reg + RND_W'(1);
                if (round_last)
                begin
                    round_next = '0;
                    state_next = need_rot_reg ? ST_ROT : ST_PICK;
                end
            end
            ST_ROT:
            begin
                round_next = round_reg + RND_W'(1);
                if (match)
                begin
                    found_next = 1'b1;
                end
                if (round_last)
                begin
                    round_next = '0;
                    state_next = ST_SORT_B;
                    if (found_reg || match)
                    begin
                        job_count_next = job_count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pass_status_next = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_SORT_B:
            begin
                round_next = round_reg + RND_W'(1);
                if (round_last)
                begin
                    round_next = '0;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                round_next = '0;
                state_next = ST_SORT_C;
                if (run_valid_reg && run_finished_reg)
                begin
                    job_count_next = job_count_reg - CNT_W'(1);
                    run_valid_next = 1'b0;
                end
                run_finished_next = 1'b0;
                if (cell_q[0].valid)
                begin
                    run_valid_next  = 1'b1;
                    run_number_next = cell_q[0].number;
                    run_level_next  = cell_q[0].level;
                end
            end
            ST_SORT_C:
            begin
                round_next = round_reg + RND_W'(1);
                if (round_last)
                begin
                    round_next = '0;
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                push                   = 1'b1;
                push_data.status       = pass_status_reg;
                push_data.pass_done    = 1'b1;
                push_data.assigned_job = assigned_reg;
                countdown_next         = run_valid_reg
                                         ? slice_pick(run_level_reg, slice_one_reg,
                                                      slice_two_reg, slice_three_reg)
                                         : 8'd1;
                state_next             = ST_IDLE;
            end
        endcase
    end

    // Advance the output queue
    always_comb
    begin
        q_next[0]  = q_reg[0];
        q_next[1]  = q_reg[1];
        q_cnt_next = q_cnt_reg;
        if (pop)
        begin
            q_next[0]  = q_reg[1];
            q_cnt_next = q_cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (q_cnt_next == 2'd0)
            begin
                q_next[0] = push_data;
            end
            else
            begin
                q_next[1] = push_data;
            end
            q_cnt_next = q_cnt_next + 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            round_reg        <= '0;
            countdown_reg    <= 8'd1;
            number_reg       <= 16'd0;
            job_count_reg    <= '0;
            run_valid_reg    <= 1'b0;
            run_finished_reg <= 1'b0;
            need_rot_reg     <= 1'b0;
            found_reg        <= 1'b0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            cmd_cnt_reg      <= '0;
            q_cnt_reg        <= 2'd0;
            slice_one_reg    <= 8'd1;
            slice_two_reg    <= 8'd2;
            slice_three_reg  <= 8'd5;
            threshold_reg    <= 8'd10;
        end
        else
        begin
            state_reg        <= state_next;
            round_reg        <= round_next;
            countdown_reg    <= countdown_next;
            number_reg       <= number_next;
            job_count_reg    <= job_count_next;
            run_valid_reg    <= run_valid_next;
            run_finished_reg <= run_finished_next;
            need_rot_reg     <= need_rot_next;
            found_reg        <= found_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            cmd_cnt_reg      <= cmd_cnt_next;
            q_cnt_reg        <= q_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SLICE_ONE:   slice_one_reg   <= cfg_data;
                    REG_SLICE_TWO:   slice_two_reg   <= cfg_data;
                    REG_SLICE_THREE: slice_three_reg <= cfg_data;
                    default:         threshold_reg   <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        run_number_reg  <= run_number_next;
        run_level_reg   <= run_level_next;
        pass_status_reg <= pass_status_next;
        assigned_reg    <= assigned_next;
        target_reg      <= target_next;
        q_reg[0]        <= q_next[0];
        q_reg[1]        <= q_next[1];
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = {2'b00, q_reg[0]};

`ifndef SYNTHESIS
    a_job_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_count_reg <= CNT_W'(JOB_SLOTS))
        else $error("job count exceeds slot count");

    a_cmd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_cnt_reg <= CCW'(COMMAND_DEPTH))
        else $error("command buffer count exceeds depth");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_cnt_reg != 2'd2) || pop)
        else $error("output queue overflow");

    a_load_free_cell: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !cell_q[JOB_SLOTS-1].valid)
        else $error("enqueue into an occupied tail cell");

    a_pick_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) && cell_q[0].valid |=> run_valid_reg)
        else $error("picked head did not start running");
`endif

endmodule
